// ===== hdl/bds_pkg.sv =====
// ----------------------------------------------------------------------------
// bds_pkg
// Shared constants and types of the 2x2 box-filter downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int AW         = $clog2(LINE_DEPTH);
  localparam int CH         = 4;
  localparam int PW         = 9;
  localparam int MW         = CH * PW;

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_CHANNELS   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CH-1:0][PW-1:0] pair;
    logic                  use_self;
    logic                  last;
  } s1_t;

endpackage

// ===== hdl/bds_line_mem.sv =====
// ----------------------------------------------------------------------------
// bds_line_mem
// Line store of horizontal pair sums from even source rows.
// ----------------------------------------------------------------------------
module bds_line_mem (
  input  logic                clk,
  input  logic                we,
  input  logic                re,
  input  logic [bds_pkg::AW-1:0] addr,
  input  logic [bds_pkg::MW-1:0] wdata,
  output logic [bds_pkg::MW-1:0] rdata_r
);
  import bds_pkg::*;

  logic [MW-1:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

// ===== hdl/bds_front.sv =====
// ----------------------------------------------------------------------------
// bds_front
// Configuration registers, raster position, held left texel, pair sums and
// the first pipeline register.
// ----------------------------------------------------------------------------
module bds_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_acc,
  input  logic [31:0]            in_tdata,
  input  logic                   adv,
  output logic                   s1_valid_r,
  output bds_pkg::s1_t           s1_r,
  output logic                   mem_we,
  output logic                   mem_re,
  output logic [bds_pkg::AW-1:0] mem_addr,
  output logic [bds_pkg::MW-1:0] mem_wdata
);
  import bds_pkg::*;

  logic [12:0]           width_r;
  logic [15:0]           height_r;
  logic [2:0]            chan_r;
  logic [XW-1:0]         x_r, x_nxt;
  logic [15:0]           y_r, y_nxt;
  logic [CH-1:0][7:0]    held_r;

  logic [12:0]           w_eff;
  logic [15:0]           h_eff;
  logic [2:0]            lanes;
  logic [11:0]           ow;
  logic [14:0]           oh;
  logic                  w_one, h_one, have_pair, emit, restart;
  logic [CH-1:0][7:0]    texel;
  logic [CH-1:0][PW-1:0] pair;
  logic [AW-1:0]         ox;
  logic [14:0]           oy;
  s1_t                   s1_nxt;

  always_comb begin
    w_eff = width_r;
    if (width_r == 13'd0) begin
      w_eff = 13'd1;
    end else if (width_r > 13'(MAX_WIDTH)) begin
      w_eff = 13'(MAX_WIDTH);
    end
    h_eff = (height_r == 16'd0) ? 16'd1 : height_r;
    lanes = chan_r;
    if (chan_r == 3'd0) begin
      lanes = 3'd1;
    end else if (chan_r > 3'd4) begin
      lanes = 3'd4;
    end
    ow = (w_eff[12:1] == 12'd0) ? 12'd1 : w_eff[12:1];
    oh = (h_eff[15:1] == 15'd0) ? 15'd1 : h_eff[15:1];
    w_one = (w_eff == 13'd1);
    h_one = (h_eff == 16'd1);
    for (int i = 0; i < CH; i++) begin
      texel[i] = (3'(i) < lanes) ? in_tdata[8*i +: 8] : 8'd0;
      pair[i]  = w_one ? {texel[i], 1'b0} : ({1'b0, held_r[i]} + {1'b0, texel[i]});
    end
    have_pair = w_one | x_r[0];
    emit      = have_pair & (h_one | y_r[0]);
    ox        = w_one ? '0 : x_r[XW-1:1];
    oy        = h_one ? 15'd0 : y_r[15:1];
    s1_nxt.pair     = pair;
    s1_nxt.use_self = h_one;
    s1_nxt.last     = ({1'b0, ox} == ow - 12'd1) && (oy == oh - 15'd1);
    mem_we    = in_acc & have_pair & ~h_one & ~y_r[0];
    mem_re    = in_acc & emit & ~h_one;
    mem_addr  = ox;
    mem_wdata = pair;
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (in_acc) begin
      if ({1'b0, x_r} + 13'd1 >= w_eff) begin
        x_nxt = '0;
        y_nxt = ({1'b0, y_r} + 17'd1 >= {1'b0, h_eff}) ? 16'd0 : y_r + 16'd1;
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(cfg_index)) inside
      CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_CHANNELS: restart = cfg_wr;
      default:                                     restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd1;
      height_r <= 16'd1;
      chan_r   <= 3'd4;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SRC_WIDTH:  width_r  <= cfg_data[12:0];
        CFG_SRC_HEIGHT: height_r <= cfg_data;
        CFG_CHANNELS:   chan_r   <= cfg_data[2:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      x_r    <= '0;
      y_r    <= '0;
      held_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      if (in_acc && !have_pair) begin
        held_r <= texel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= emit;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, x_r} < w_eff)
    else $error("column position beyond image width");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> x_r == '0 && y_r == 16'd0)
    else $error("register write did not restart the image");
`endif

endmodule

// ===== hdl/bds_out.sv =====
// ----------------------------------------------------------------------------
// bds_out
// Rounded mean of the two pair sums and the result register.
// ----------------------------------------------------------------------------
module bds_out (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s1_valid,
  input  bds_pkg::s1_t           s1,
  input  logic [bds_pkg::MW-1:0] line_data,
  input  logic                   out_tready,
  output logic                   adv,
  output logic                   out_tvalid,
  output logic [31:0]            out_tdata,
  output logic                   out_tlast
);
  import bds_pkg::*;

  logic [CH-1:0][PW-1:0] other;
  logic [CH-1:0][7:0]    mean;
  logic [PW+1:0]         sum [CH];

  always_comb begin
    other = s1.use_self ? s1.pair : line_data;
    for (int i = 0; i < CH; i++) begin
      sum[i]  = {2'b00, s1.pair[i]} + {2'b00, other[i]} + 11'd2;
      mean[i] = sum[i][9:2];
    end
    adv = ~out_tvalid | out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (adv) begin
      out_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_tdata <= mean;
      out_tlast <= s1.last;
    end
  end

endmodule

// ===== hdl/box_downsample_2x2.sv =====
// ----------------------------------------------------------------------------
// box_downsample_2x2
// Streaming 2x2 box-filter mip downsampler.
// ----------------------------------------------------------------------------
// Source texels enter in raster order at one item per clock and the half-size
// level leaves through the first pipeline register and the result register;
// the rate is set by the single pipeline of pair adder, line store read and
// rounding adder, so one texel is taken every cycle unless the output side
// holds back. Even source rows store their horizontal pair sums in a 2048 x
// 36 bit line store that needs no clearing after reset, odd rows read them
// back and give one output texel per pair, and tlast marks the final texel of
// the level. Any register write restarts the image at its first texel.
module box_downsample_2x2 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_c0, sample_c1, sample_c2, sample_c3
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_c0, out_c1, out_c2, out_c3
  output logic        out_tlast
);
  import bds_pkg::*;

  logic          cfg_wr, in_acc, adv, s1_valid_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [MW-1:0] mem_wdata, mem_rdata;
  s1_t           s1_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_tready = ~s1_valid_r | adv;
  assign in_acc    = in_tvalid & in_tready;

  bds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_acc     (in_acc),
    .in_tdata   (in_tdata),
    .adv        (adv),
    .s1_valid_r (s1_valid_r),
    .s1_r       (s1_r),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata)
  );

  bds_line_mem u_line (
    .clk     (clk),
    .we      (mem_we),
    .re      (mem_re),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata_r (mem_rdata)
  );

  bds_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1         (s1_r),
    .line_data  (mem_rdata),
    .out_tready (out_tready),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the result register is empty");
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_r))
    else $error("first stage item lost under back pressure");
`endif

endmodule
